// ===== rtl/core/lz_rle_byte_decompressor_defines.svh =====
// ----------------------------------------------------------------------------
// lz_rle_byte_decompressor_defines.svh
// assertion macros used by the decompressor checker
// ----------------------------------------------------------------------------
`ifndef LZ_RLE_BYTE_DECOMPRESSOR_DEFINES_SVH
`define LZ_RLE_BYTE_DECOMPRESSOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LZRB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lzrb: same-cycle property violated");

// next-cycle implication, disabled during reset
`define LZRB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lzrb: next-cycle property violated");

`endif

// ===== rtl/core/lzrb_pkg.sv =====
// ----------------------------------------------------------------------------
// lzrb_pkg
// types and codes of the lz/rle byte decompressor
// ----------------------------------------------------------------------------
package lzrb_pkg;

  // token counts and copy distances never exceed 4114
  localparam int unsigned CNT_W = 13;

  // item opcodes
  localparam logic [1:0] OP_FEED    = 2'd0;
  localparam logic [1:0] OP_STEP    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_BUSY_REFUSED = 2'd1;
  localparam logic [1:0] ST_IDLE_STEP    = 2'd2;
  localparam logic [1:0] ST_TOO_FAR      = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       busy_res;
    logic [1:0] status;
  } out_t;

endpackage

// ===== rtl/core/lz_rle_byte_decompressor.sv =====
// a result is registered in stage 1 and then in the output register
// throughput: one item per cycle unless output stalls, fills and copies included;
//   the history memory has one write port and one registered read port, and copy
//   distances of three or more keep the read off the single pending write
// reset: all parse and run state clears at once; history keeps its contents
// ----------------------------------------------------------------------------
// lz_rle_byte_decompressor
// byte-serial decoder for 16-bit flag word lz77 / run-length compressed data
// ----------------------------------------------------------------------------
module lz_rle_byte_decompressor #(
  parameter int unsigned HISTORY_DEPTH = 8192
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lzrb_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lzrb_pkg::out_t out_data_o
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned PW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned CW = lzrb_pkg::CNT_W;
  localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(HISTORY_DEPTH);
  localparam logic [AW-1:0] WP_LAST   = AW'(HISTORY_DEPTH - 1);
  localparam logic [PW-1:0] PROD_MAX  = PW'(HISTORY_DEPTH);

  // parse phases
  localparam logic [2:0] PH_FLAG_LO   = 3'd0;
  localparam logic [2:0] PH_FLAG_HI   = 3'd1;
  localparam logic [2:0] PH_TOKEN     = 3'd2;
  localparam logic [2:0] PH_FILL_VAL  = 3'd3;
  localparam logic [2:0] PH_LFILL_CNT = 3'd4;
  localparam logic [2:0] PH_LFILL_VAL = 3'd5;
  localparam logic [2:0] PH_COPY_DIST = 3'd6;
  localparam logic [2:0] PH_LCOPY_CNT = 3'd7;

  // parse and run state
  logic [15:0]   flag_word_q, flag_word_d;
  logic [4:0]    flags_left_q, flags_left_d;
  logic [2:0]    phase_q, phase_d;
  logic [3:0]    kind_q, kind_d;
  logic [3:0]    low_q, low_d;
  logic [CW-1:0] remain_q, remain_d;
  logic [7:0]    fill_q, fill_d;
  logic [CW-1:0] dist_q, dist_d;
  logic [AW-1:0] wp_q, wp_d;
  logic [PW-1:0] prod_q, prod_d;

  // stage 1: item decoded, history read in flight
  logic          s1_valid_q;
  logic          s1_wr_q;
  logic          s1_use_rd_q;
  logic [7:0]    s1_byte_q;
  logic          s1_busy_q;
  logic [1:0]    s1_status_q;
  logic [AW-1:0] s1_addr_q;

  // output register
  logic           out_valid_q;
  lzrb_pkg::out_t out_q;

  // history memory
  logic [7:0] hist_mem [HISTORY_DEPTH];
  logic [7:0] rd_q;

  logic          in_xfer;
  logic          s1_adv;
  logic          put;
  logic          use_rd;
  logic [7:0]    put_byte;
  logic [1:0]    status;
  logic [4:0]    lf_dec;
  logic          flag_bit;
  logic [CW-1:0] dist_new;
  logic [AW:0]   src_wrap;
  logic [AW-1:0] src_addr;
  logic [7:0]    s1_data;
  logic [7:0]    b;

  // ---- handshake: stage 1 moves on whenever the output register can take it
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign b = in_data_i.data_byte;

  // ---- helpers shared by the decode below
  assign lf_dec   = flags_left_q - 5'd1;
  assign flag_bit = flag_word_q[lf_dec[3:0]];
  // copy distance formed from the distance byte and the header low nibble
  assign dist_new = CW'(low_q) + CW'(3) + {1'b0, b, 4'b0000};

  // copy source, wrapping around the history ring
  assign src_wrap = {1'b0, wp_q} + DEPTH_EXT - (AW + 1)'(dist_q);
  assign src_addr = (wp_q >= AW'(dist_q)) ? (wp_q - AW'(dist_q)) : src_wrap[AW-1:0];

  // ---- decode of the accepted item
  always_comb begin
    flag_word_d  = flag_word_q;
    flags_left_d = flags_left_q;
    phase_d      = phase_q;
    kind_d       = kind_q;
    low_d        = low_q;
    remain_d     = remain_q;
    fill_d       = fill_q;
    dist_d       = dist_q;
    wp_d         = wp_q;
    prod_d       = prod_q;
    put          = 1'b0;
    use_rd       = 1'b0;
    put_byte     = 8'd0;
    status       = lzrb_pkg::ST_OK;

    if (in_xfer) begin
      case (in_data_i.opcode)
        lzrb_pkg::OP_RESTART: begin
          flag_word_d  = '0;
          flags_left_d = '0;
          phase_d      = PH_FLAG_LO;
          kind_d       = '0;
          low_d        = '0;
          remain_d     = '0;
          fill_d       = '0;
          dist_d       = '0;
          wp_d         = '0;
          prod_d       = '0;
        end
        lzrb_pkg::OP_STEP: begin
          if (remain_q == '0) begin
            status = lzrb_pkg::ST_IDLE_STEP;
          end else begin
            put      = 1'b1;
            remain_d = remain_q - CW'(1);
            if (kind_q <= 4'd1) begin
              put_byte = fill_q;
            end else begin
              use_rd = 1'b1;
            end
          end
        end
        lzrb_pkg::OP_FEED: begin
          if (remain_q != '0) begin
            status = lzrb_pkg::ST_BUSY_REFUSED;
          end else begin
            case (phase_q)
              PH_FLAG_LO: begin
                flag_word_d = {8'd0, b};
                phase_d     = PH_FLAG_HI;
              end
              PH_FLAG_HI: begin
                flag_word_d  = {b, flag_word_q[7:0]};
                flags_left_d = 5'd16;
                phase_d      = PH_TOKEN;
              end
              PH_TOKEN: begin
                if (flags_left_q != '0) begin
                  flags_left_d = lf_dec;
                end
                if (!flag_bit) begin
                  // literal goes straight out
                  put      = 1'b1;
                  put_byte = b;
                  phase_d  = (flags_left_d != '0) ? PH_TOKEN : PH_FLAG_LO;
                end else begin
                  kind_d = b[7:4];
                  low_d  = b[3:0];
                  case (b[7:4])
                    4'd0:    phase_d = PH_FILL_VAL;
                    4'd1:    phase_d = PH_LFILL_CNT;
                    default: phase_d = PH_COPY_DIST;
                  endcase
                end
              end
              PH_FILL_VAL: begin
                fill_d   = b;
                remain_d = CW'(low_q) + CW'(3);
                phase_d  = (flags_left_q != '0) ? PH_TOKEN : PH_FLAG_LO;
              end
              PH_LFILL_CNT: begin
                // count byte parks in the fill register
                fill_d  = b;
                phase_d = PH_LFILL_VAL;
              end
              PH_LFILL_VAL: begin
                remain_d = CW'(19) + {1'b0, fill_q, 4'b0000} + CW'(low_q);
                fill_d   = b;
                phase_d  = (flags_left_q != '0) ? PH_TOKEN : PH_FLAG_LO;
              end
              PH_COPY_DIST: begin
                dist_d = dist_new;
                if (kind_q == 4'd2) begin
                  phase_d = PH_LCOPY_CNT;
                end else begin
                  phase_d = (flags_left_q != '0) ? PH_TOKEN : PH_FLAG_LO;
                  if (PW'(dist_new) > prod_q) begin
                    status = lzrb_pkg::ST_TOO_FAR;
                  end else begin
                    remain_d = CW'(kind_q);
                  end
                end
              end
              PH_LCOPY_CNT: begin
                phase_d = (flags_left_q != '0) ? PH_TOKEN : PH_FLAG_LO;
                if (PW'(dist_q) > prod_q) begin
                  status = lzrb_pkg::ST_TOO_FAR;
                end else begin
                  remain_d = CW'(b) + CW'(16);
                end
              end
              default: begin
                phase_d = PH_FLAG_LO;
              end
            endcase
          end
        end
        default: begin
          // unused opcode leaves everything alone
        end
      endcase

      // every emitted byte advances the ring and the saturating output count
      if (put) begin
        wp_d   = (wp_q == WP_LAST) ? '0 : (wp_q + AW'(1));
        prod_d = (prod_q == PROD_MAX) ? prod_q : (prod_q + PW'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_word_q  <= '0;
      flags_left_q <= '0;
      phase_q      <= PH_FLAG_LO;
      kind_q       <= '0;
      low_q        <= '0;
      remain_q     <= '0;
      fill_q       <= '0;
      dist_q       <= '0;
      wp_q         <= '0;
      prod_q       <= '0;
    end else begin
      flag_word_q  <= flag_word_d;
      flags_left_q <= flags_left_d;
      phase_q      <= phase_d;
      kind_q       <= kind_d;
      low_q        <= low_d;
      remain_q     <= remain_d;
      fill_q       <= fill_d;
      dist_q       <= dist_d;
      wp_q         <= wp_d;
      prod_q       <= prod_d;
    end
  end

  // ---- stage 1 and output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // stage 1 payload; the write address is the ring position before the advance
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_wr_q     <= put;
      s1_use_rd_q <= use_rd;
      s1_byte_q   <= put_byte;
      s1_busy_q   <= (remain_d != '0);
      s1_status_q <= status;
      s1_addr_q   <= wp_q;
    end
  end

  // copy bytes come from the history read, everything else was decided at decode
  assign s1_data = s1_use_rd_q ? rd_q : s1_byte_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q.out_valid <= s1_wr_q;
      out_q.out_byte  <= s1_wr_q ? s1_data : 8'd0;
      out_q.busy_res  <= s1_busy_q;
      out_q.status    <= s1_status_q;
    end
  end

  // ---- history: byte written back as it leaves stage 1, read at transfer in;
  // a read in the same cycle as that write is at least two bytes behind it
  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_wr_q) begin
      hist_mem[s1_addr_q] <= s1_data;
    end
    if (in_xfer && use_rd) begin
      rd_q <= hist_mem[src_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/lzrb_checker.sv =====
// ----------------------------------------------------------------------------
// lzrb_checker
// port-level checks on the decompressor result channel
// ----------------------------------------------------------------------------
`include "lz_rle_byte_decompressor_defines.svh"

module lzrb_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input lzrb_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input lzrb_pkg::out_t out_data_o
);

  logic res_shown;
  logic in_seen;
  logic byte_shown;
  logic blank_shown;
  logic refused_shown;
  logic idle_shown;
  logic out_held;

  assign res_shown = out_valid_o;
  // input side is watched only through the bound ports
  assign in_seen   = in_valid_i && !in_stall_o && (in_data_i.opcode != lzrb_pkg::OP_FEED);

  assign byte_shown    = res_shown && out_data_o.out_valid;
  assign blank_shown   = res_shown && !out_data_o.out_valid;
  assign refused_shown = res_shown && (out_data_o.status == lzrb_pkg::ST_BUSY_REFUSED);
  assign idle_shown    = res_shown && !in_seen &&
                         (out_data_o.status == lzrb_pkg::ST_IDLE_STEP ||
                          out_data_o.status == lzrb_pkg::ST_TOO_FAR);
  assign out_held      = out_valid_o && out_stall_i;

  // a produced byte never comes with an error status
  `LZRB_ASSERT_IMP(a_byte_ok, clk_i, rst_ni, byte_shown, out_data_o.status == lzrb_pkg::ST_OK)
  // no byte means a zero byte field
  `LZRB_ASSERT_IMP(a_byte_zero, clk_i, rst_ni, blank_shown, out_data_o.out_byte == 8'd0)
  // a refused feed only happens while a run is pending, and it stays pending
  `LZRB_ASSERT_IMP(a_refused_busy, clk_i, rst_ni, refused_shown, out_data_o.busy_res)
  // idle steps and dropped copies leave nothing pending
  `LZRB_ASSERT_IMP(a_idle_clear, clk_i, rst_ni, idle_shown, !out_data_o.busy_res)
  // a stalled result holds
  `LZRB_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_data_o))

endmodule

bind lz_rle_byte_decompressor lzrb_checker u_lzrb_checker (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the lz/rle byte decompressor against an in-bench decoder model: a
// short table of hand-picked items, then well-formed compressed streams with
// random content mixed with noise, under four idling patterns on the input
// and output sides
// ----------------------------------------------------------------------------
module testbench;

  localparam int HIST_DEPTH   = 8192;
  localparam int MAX_DIST     = 4098;  // 3 + 15 + 16 * 255
  localparam int QUIET_LIMIT  = 1000;  // cycles without any transfer
  localparam int PHASE_ITEMS  = 320;
  localparam int MAX_REPORTS  = 10;
  localparam int N_DIRECTED   = 25;

  // opcode the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // decoder parse position, mirrors the block's own sequencing
  typedef enum logic [2:0] {
    WAIT_FLAG_LO, WAIT_FLAG_HI, WAIT_TOKEN, WAIT_FILL_VAL,
    WAIT_LFILL_CNT, WAIT_LFILL_VAL, WAIT_COPY_DIST, WAIT_LCOPY_CNT
  } dec_phase_e;

  // one row of the hand-written table; has_want marks a result typed in by hand
  typedef struct packed {
    lzrb_pkg::in_t  item;
    logic           has_want;
    lzrb_pkg::out_t want;
  } row_t;

  // hand-picked opening: idle step, unused opcode, literals at both byte
  // extremes, a copy reaching before the start, a short fill with a feed
  // refused while busy, a short copy, a long copy at the farthest
  // distance and longest count that is dropped, and a restart
  localparam row_t DIRECTED [N_DIRECTED] = '{
    '{'{lzrb_pkg::OP_STEP, 8'h00}, 1'b1, '{1'b0, 8'h00, 1'b0, lzrb_pkg::ST_IDLE_STEP}},
    '{'{OP_UNUSED, 8'h5A}, 1'b1, '{1'b0, 8'h00, 1'b0, lzrb_pkg::ST_OK}},
    '{'{lzrb_pkg::OP_RESTART, 8'hFF}, 1'b1, '{1'b0, 8'h00, 1'b0, lzrb_pkg::ST_OK}},
    '{'{lzrb_pkg::OP_FEED, 8'h00}, 1'b1, '{1'b0, 8'h00, 1'b0, lzrb_pkg::ST_OK}},
    '{'{lzrb_pkg::OP_FEED, 8'h3C}, 1'b0, '0},
    '{'{lzrb_pkg::OP_FEED, 8'h00}, 1'b1, '{1'b1, 8'h00, 1'b0, lzrb_pkg::ST_OK}},
    '{'{lzrb_pkg::OP_FEED, 8'hFF}, 1'b1, '{1'b1, 8'hFF, 1'b0, lzrb_pkg::ST_OK}},
    '{'{lzrb_pkg::OP_FEED, 8'h30}, 1'b0, '0},
    '{'{lzrb_pkg::OP_FEED, 8'h00}, 1'b1, '{1'b0, 8'h00, 1'b0, lzrb_pkg::ST_TOO_FAR}},
    '{'{lzrb_pkg::OP_FEED, 8'h00}, 1'b0, '0},
    '{'{lzrb_pkg::OP_FEED, 8'hA5}, 1'b0, '0},
    '{'{lzrb_pkg::OP_FEED, 8'h12}, 1'b1, '{1'b0, 8'h00, 1'b1, lzrb_pkg::ST_BUSY_REFUSED}},
    '{'{lzrb_pkg::OP_STEP, 8'h00}, 1'b0, '0},
    '{'{lzrb_pkg::OP_STEP, 8'hFF}, 1'b0, '0},
    '{'{lzrb_pkg::OP_STEP, 8'h00}, 1'b0, '0},
    '{'{lzrb_pkg::OP_STEP, 8'h00}, 1'b1, '{1'b0, 8'h00, 1'b0, lzrb_pkg::ST_IDLE_STEP}},
    '{'{lzrb_pkg::OP_FEED, 8'h32}, 1'b0, '0},
    '{'{lzrb_pkg::OP_FEED, 8'h00}, 1'b0, '0},
    '{'{lzrb_pkg::OP_STEP, 8'h00}, 1'b0, '0},
    '{'{lzrb_pkg::OP_STEP, 8'h00}, 1'b0, '0},
    '{'{lzrb_pkg::OP_STEP, 8'h00}, 1'b0, '0},
    '{'{lzrb_pkg::OP_FEED, 8'h2F}, 1'b0, '0},
    '{'{lzrb_pkg::OP_FEED, 8'hFF}, 1'b0, '0},
    '{'{lzrb_pkg::OP_FEED, 8'hFF}, 1'b1, '{1'b0, 8'h00, 1'b0, lzrb_pkg::ST_TOO_FAR}},
    '{'{lzrb_pkg::OP_RESTART, 8'h00}, 1'b1, '{1'b0, 8'h00, 1'b0, lzrb_pkg::ST_OK}}
  };

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  lzrb_pkg::in_t  in_data_i   = '0;
  logic           out_stall_i = 1'b0;
  logic           in_stall_o;
  logic           out_valid_o;
  lzrb_pkg::out_t out_data_o;

  lz_rle_byte_decompressor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // decoder model state
  // ---------------------------------------------------------------------------
  logic [15:0] m_flags;
  logic [4:0]  m_flags_left;
  dec_phase_e  m_phase;
  logic [3:0]  m_kind;
  logic [3:0]  m_low;
  logic [12:0] m_run_left;    // bytes still owed by the current fill or copy
  logic [7:0]  m_fill;        // fill value, or long fill count byte in transit
  logic [12:0] m_dist;
  logic [12:0] m_wpos;        // wraps with the history depth
  int          m_produced;    // saturates at the history depth
  logic [7:0]  m_hist [HIST_DEPTH];

  // results waiting for their transfer out, oldest first
  lzrb_pkg::out_t awaited_results [$];

  int items_sent;
  int results_seen;
  int bytes_checked;
  int too_far_seen;
  int refused_seen;
  int mismatches;
  int quiet_cycles;
  int in_gap_pct;
  int out_stall_pct;
  int phase_end;

  function automatic void clear_decoder();
    m_flags      = '0;
    m_flags_left = '0;
    m_phase      = WAIT_FLAG_LO;
    m_kind       = '0;
    m_low        = '0;
    m_run_left   = '0;
    m_fill       = '0;
    m_dist       = '0;
    m_wpos       = '0;
    m_produced   = 0;
  endfunction

  function automatic void push_history(logic [7:0] b);
    m_hist[m_wpos] = b;
    m_wpos = m_wpos + 13'd1;
    if (m_produced < HIST_DEPTH) m_produced++;
  endfunction

  function automatic void end_token();
    m_phase = (m_flags_left != 0) ? WAIT_TOKEN : WAIT_FLAG_LO;
  endfunction

  // a copy token is complete: drop it if it reaches before the first byte
  function automatic logic [1:0] begin_copy(int count);
    end_token();
    if (int'(m_dist) > m_produced) return lzrb_pkg::ST_TOO_FAR;
    m_run_left = 13'(count);
    return lzrb_pkg::ST_OK;
  endfunction

  // advances the model by one item and returns the result it produces
  function automatic lzrb_pkg::out_t decode_item(lzrb_pkg::in_t it);
    lzrb_pkg::out_t r;
    logic [7:0]     b;
    logic [12:0]    src;
    r = '0;
    b = it.data_byte;
    case (it.opcode)
      lzrb_pkg::OP_RESTART: clear_decoder();
      lzrb_pkg::OP_STEP: begin
        if (m_run_left == 0) begin
          r.status = lzrb_pkg::ST_IDLE_STEP;
        end else begin
          if (m_kind <= 4'd1) begin
            r.out_byte = m_fill;
          end else begin
            src = m_wpos - m_dist;  // modulo the history depth
            r.out_byte = m_hist[src];
          end
          push_history(r.out_byte);
          r.out_valid = 1'b1;
          m_run_left--;
        end
      end
      lzrb_pkg::OP_FEED: begin
        if (m_run_left != 0) begin
          r.status = lzrb_pkg::ST_BUSY_REFUSED;
        end else begin
          case (m_phase)
            WAIT_FLAG_LO: begin
              m_flags = {8'h00, b};
              m_phase = WAIT_FLAG_HI;
            end
            WAIT_FLAG_HI: begin
              m_flags[15:8] = b;
              m_flags_left  = 5'd16;
              m_phase       = WAIT_TOKEN;
            end
            WAIT_TOKEN: begin
              // flags are consumed from the top bit down
              if (!m_flags[m_flags_left - 5'd1]) begin
                m_flags_left--;
                push_history(b);
                r.out_valid = 1'b1;
                r.out_byte  = b;
                end_token();
              end else begin
                m_flags_left--;
                m_kind = b[7:4];
                m_low  = b[3:0];
                if (m_kind == 4'd0)      m_phase = WAIT_FILL_VAL;
                else if (m_kind == 4'd1) m_phase = WAIT_LFILL_CNT;
                else                     m_phase = WAIT_COPY_DIST;
              end
            end
            WAIT_FILL_VAL: begin
              m_fill     = b;
              m_run_left = 13'(int'(m_low) + 3);
              end_token();
            end
            WAIT_LFILL_CNT: begin
              m_fill  = b;
              m_phase = WAIT_LFILL_VAL;
            end
            WAIT_LFILL_VAL: begin
              m_run_left = 13'(19 + 16 * int'(m_fill) + int'(m_low));
              m_fill     = b;
              end_token();
            end
            WAIT_COPY_DIST: begin
              m_dist = 13'(3 + int'(m_low) + 16 * int'(b));
              if (m_kind == 4'd2) m_phase = WAIT_LCOPY_CNT;
              else r.status = begin_copy(int'(m_kind));
            end
            default: r.status = begin_copy(int'(b) + 16);
          endcase
        end
      end
      default: ;
    endcase
    r.busy_res = (m_run_left != 0);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // output side: random stall, result check, watchdog
  // ---------------------------------------------------------------------------
  function automatic void check_result(lzrb_pkg::out_t got);
    lzrb_pkg::out_t want;
    results_seen++;
    if (awaited_results.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("result %0d arrived with nothing expected: valid %0b byte %02h busy %0b st %0d",
                 results_seen, got.out_valid, got.out_byte, got.busy_res, got.status);
      return;
    end
    want = awaited_results.pop_front();
    if (got.out_valid !== want.out_valid || got.out_byte !== want.out_byte ||
        got.busy_res !== want.busy_res || got.status !== want.status) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("result %0d: expected valid %0b byte %02h busy %0b st %0d, got %0b %02h %0b %0d",
                 results_seen, want.out_valid, want.out_byte, want.busy_res, want.status,
                 got.out_valid, got.out_byte, got.busy_res, got.status);
    end else begin
      if (got.out_valid) bytes_checked++;
      if (got.status == lzrb_pkg::ST_TOO_FAR) too_far_seen++;
      if (got.status == lzrb_pkg::ST_BUSY_REFUSED) refused_seen++;
    end
  endfunction

  // everything is sampled at the edge before any update lands
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < out_stall_pct);
      if (out_valid_o && !out_stall_i) check_result(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, awaited_results.size());
        $display("testbench failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // valid stays high from one transfer to the next unless a gap is rolled
  task automatic send_item(input lzrb_pkg::in_t it, input logic has_want = 1'b0,
                           input lzrb_pkg::out_t want = '0);
    lzrb_pkg::out_t pred;
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // transfer happened at this edge
    pred = decode_item(it);
    awaited_results.push_back(has_want ? want : pred);
    items_sent++;
  endtask

  task automatic feed(input logic [7:0] b);
    send_item({lzrb_pkg::OP_FEED, b});
  endtask

  task automatic step();
    send_item({lzrb_pkg::OP_STEP, 8'($urandom)});
  endtask

  task automatic restart_decoder();
    send_item({lzrb_pkg::OP_RESTART, 8'($urandom)});
  endtask

  // sender holds off until the last result has been taken
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  // a new stream must start on a flag word with no run pending
  task automatic prepare_stream();
    if (m_run_left != 0 || m_phase != WAIT_FLAG_LO) restart_decoder();
  endtask

  // occasional stray item between tokens; cut is set when it aborts the stream
  task automatic maybe_noise(output logic cut);
    int r;
    cut = 1'b0;
    r = $urandom_range(999);
    if (r < 5) begin
      restart_decoder();
      cut = 1'b1;
    end else if (r < 30) begin
      step();
    end else if (r < 45) begin
      send_item({OP_UNUSED, 8'($urandom)});
    end
  endtask

  // one fill or copy token with random fields, then its run, stepped out
  task automatic send_token(output logic cut);
    int         r;
    int         maxd;
    int         back_dist;
    int         enc;
    logic [3:0] kind;
    cut = 1'b0;
    r = $urandom_range(99);
    if (r < 20) begin
      feed({4'h0, 4'($urandom)});
      feed(8'($urandom));
    end else if (r < 35) begin
      // long fills stay short most of the time
      feed({4'h1, 4'($urandom)});
      feed(($urandom_range(49) == 0) ? 8'($urandom) : 8'($urandom_range(3)));
      feed(8'($urandom));
    end else begin
      maxd = (m_produced < MAX_DIST) ? m_produced : MAX_DIST;
      if ($urandom_range(9) == 0 || maxd < 3) back_dist = maxd + $urandom_range(1, 24);
      else if ($urandom_range(3) == 0) back_dist = $urandom_range(3, (maxd < 6) ? maxd : 6);
      else back_dist = $urandom_range(3, maxd);
      if (back_dist < 3) back_dist = 3;
      if (back_dist > MAX_DIST) back_dist = MAX_DIST;
      enc = back_dist - 3;
      if (r < 55) begin
        feed({4'h2, 4'(enc)});
        feed(8'(enc >> 4));
        feed(($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(15)));
      end else begin
        kind = 4'($urandom_range(3, 15));
        feed({kind, 4'(enc)});
        feed(8'(enc >> 4));
      end
    end
    while (m_run_left != 0) begin
      r = $urandom_range(199);
      if (r < 8) begin
        feed(8'($urandom));  // refused while the run is pending
      end else if (r < 11) begin
        send_item({OP_UNUSED, 8'($urandom)});
      end else if (r == 11) begin
        restart_decoder();
        cut = 1'b1;
        return;
      end else begin
        step();
      end
    end
    if ($urandom_range(29) == 0) step();
  endtask

  // well-formed groups: flag word, then one literal or token per flag;
  // stops early once the phase has sent its share of items
  task automatic send_stream(input int groups);
    logic [15:0] fw;
    logic        cut;
    for (int g = 0; g < groups; g++) begin
      fw = 16'($urandom);
      feed(fw[7:0]);
      feed(fw[15:8]);
      for (int i = 15; i >= 0; i--) begin
        if (items_sent >= phase_end) return;
        maybe_noise(cut);
        if (cut) return;
        if (!fw[i]) begin
          feed(8'($urandom));
        end else begin
          send_token(cut);
          if (cut) return;
        end
      end
    end
  endtask

  // broken input: any opcode, any byte, in any parse position
  task automatic send_garbage(input int n);
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      op = 2'($urandom_range(3));
      if (op == lzrb_pkg::OP_RESTART && $urandom_range(3) != 0) op = lzrb_pkg::OP_FEED;
      send_item({op, 8'($urandom)});
    end
  endtask

  task automatic random_phase(input int target);
    phase_end = items_sent + target;
    while (items_sent < phase_end) begin
      prepare_stream();
      if ($urandom_range(15) == 0) send_garbage($urandom_range(10, 40));
      else send_stream($urandom_range(1, 3));
    end
  endtask

  task automatic set_idling(input int gap_pct, input int stall_pct);
    in_gap_pct    = gap_pct;
    out_stall_pct = stall_pct;
  endtask

  initial begin
    items_sent    = 0;
    results_seen  = 0;
    bytes_checked = 0;
    too_far_seen  = 0;
    refused_seen  = 0;
    mismatches    = 0;
    quiet_cycles  = 0;
    phase_end     = 0;
    set_idling(0, 0);
    clear_decoder();
    for (int i = 0; i < HIST_DEPTH; i++) m_hist[i] = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++)
      send_item(DIRECTED[i].item, DIRECTED[i].has_want, DIRECTED[i].want);
    hold_until_drained();

    // back-to-back transfers on both sides
    random_phase(PHASE_ITEMS);
    hold_until_drained();

    // sparse input
    set_idling(76, 0);
    random_phase(PHASE_ITEMS);
    hold_until_drained();

    // output mostly stalled
    set_idling(0, 76);
    random_phase(PHASE_ITEMS);
    hold_until_drained();

    // light idling on both sides
    set_idling(17, 17);
    random_phase(PHASE_ITEMS);
    hold_until_drained();
    repeat (10) @(posedge clk_i);

    $display("covered %0d items and %0d results: %0d decoded bytes, %0d dropped copies,",
             items_sent, results_seen, bytes_checked, too_far_seen);
    $display("%0d refused feeds, four idling patterns; %0d mismatches",
             refused_seen, mismatches);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
